@@ hw/rtl/circular_deque_unit_defines.svh @@
// Assertion macros shared by the deque checker.
// Depends on nothing; users supply clock and reset signals in scope.
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define CDQ_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque check failed");

// Check that a condition implies another in the following cycle.
`define CDQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

@@ hw/rtl/cdq_pkg.sv @@
// Shared types and constants of the circular deque unit.
// Used by the top level and by its checker; depends on nothing.
`default_nettype none

package cdq_pkg;

   localparam int unsigned DATA_W = 32;

   // Refused delete reads all ones.
   localparam logic [DATA_W-1:0] REFUSED_READ = '1;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_REAR  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // One transaction waiting between accept and the output register.
   typedef struct packed {
      logic              use_ram;
      logic [DATA_W-1:0] read_value;
      status_type        status;
      logic              now_empty;
      logic              now_full;
   } stage_type;

endpackage

`default_nettype wire

@@ hw/rtl/cdq_ram.sv @@
// Generic single-clock RAM, one write port and one read port, registered read.
// Depends on nothing.
`default_nettype none

module cdq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; read data holds when no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/circular_deque_unit.sv @@
// Circular deque unit: double-ended queue of DEPTH signed 32-bit words in a RAM ring.
// Depends on cdq_pkg and cdq_ram.
//
// Usage:
//   Request channel (req_valid/req_ready) carries a command and a value:
//   insert at front, insert at rear, delete from front, delete from rear.
//   Response channel (rsp_valid/rsp_ready) returns one transaction per
//   request: the removed word (-1 on a refused delete, 0 on an insert),
//   a status (done, refused full, refused empty) and the empty/full flags
//   after the operation.
//   Indices and the empty flag update at acceptance; the words live in a
//   RAM with a registered read, so a delete's word is read from the RAM
//   at acceptance and waits in its read register until the stage moves.
//   Path: each accepted transaction passes the staging register, then the
//   output register that drives rsp_valid.
//   Throughput: one transaction per cycle while the receiver takes them;
//   each operation makes at most one RAM access.
//   Stall: a staging register and the output register hold up to two
//   finished transactions; req_ready drops only when both are occupied.
//   Reset: indices go to 0, the deque is empty, both registers are empty.
`default_nettype none

module circular_deque_unit import cdq_pkg::*; #(
   parameter int unsigned DEPTH = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_command,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_read_value,
   output logic [1:0]              rsp_status,
   output logic                    rsp_now_empty,
   output logic                    rsp_now_full
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      next_slot = (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] i);
      prev_slot = (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  rear_ff, rear_in;
   logic              empty_ff, empty_in;
   logic              stg_valid_ff;
   stage_type         stg_ff, stg_in;
   logic              out_valid_ff;
   logic [DATA_W-1:0] out_value_ff;
   status_type        out_status_ff;
   logic              out_empty_ff;
   logic              out_full_ff;

   logic              accept;
   logic              stg_move;
   logic              full_now;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;
   cmd_type           cmd;

   // Ring storage
   cdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_cdq_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Handshakes
   assign stg_move  = stg_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !stg_valid_ff || stg_move;
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_command);
   assign full_now  = !empty_ff && (next_slot(rear_ff) == front_ff);

   // Decode the command: move indices, write or read one RAM entry
   always_comb begin
      front_in          = front_ff;
      rear_in           = rear_ff;
      empty_in          = empty_ff;
      wr_en             = 1'b0;
      wr_addr           = front_ff;
      rd_en             = 1'b0;
      rd_addr           = front_ff;
      stg_in.use_ram    = 1'b0;
      stg_in.read_value = '0;
      stg_in.status     = ST_DONE;
      unique case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (full_now) begin
               stg_in.status = ST_FULL;
            end else begin
               wr_en = accept;
               if (empty_ff) begin
                  front_in = '0;
                  rear_in  = '0;
                  empty_in = 1'b0;
                  wr_addr  = '0;
               end else if (cmd == CMD_PUSH_FRONT) begin
                  front_in = prev_slot(front_ff);
                  wr_addr  = front_in;
               end else begin
                  rear_in = next_slot(rear_ff);
                  wr_addr = rear_in;
               end
            end
         end
         CMD_POP_FRONT, CMD_POP_REAR: begin
            if (empty_ff) begin
               stg_in.status     = ST_EMPTY;
               stg_in.read_value = REFUSED_READ;
            end else begin
               rd_en          = accept;
               stg_in.use_ram = 1'b1;
               rd_addr        = (cmd == CMD_POP_FRONT) ? front_ff : rear_ff;
               if (front_ff == rear_ff) begin
                  empty_in = 1'b1;
                  front_in = '0;
                  rear_in  = '0;
               end else if (cmd == CMD_POP_FRONT) begin
                  front_in = next_slot(front_ff);
               end else begin
                  rear_in = prev_slot(rear_ff);
               end
            end
         end
         default: begin
            stg_in.status = ST_DONE;
         end
      endcase
      stg_in.now_empty = empty_in;
      stg_in.now_full  = !empty_in && (next_slot(rear_in) == front_in);
   end

   // Deque control state and stage/output valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         rear_ff      <= '0;
         empty_ff     <= 1'b1;
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            front_ff <= front_in;
            rear_ff  <= rear_in;
            empty_ff <= empty_in;
         end
         if (accept) begin
            stg_valid_ff <= 1'b1;
         end else if (stg_move) begin
            stg_valid_ff <= 1'b0;
         end
         if (stg_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: capture at accept, advance stage into output
   always_ff @(posedge clock) begin
      if (accept) begin
         stg_ff <= stg_in;
      end
      if (stg_move) begin
         out_value_ff  <= stg_ff.use_ram ? rd_data : stg_ff.read_value;
         out_status_ff <= stg_ff.status;
         out_empty_ff  <= stg_ff.now_empty;
         out_full_ff   <= stg_ff.now_full;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_read_value = $signed(out_value_ff);
   assign rsp_status     = out_status_ff;
   assign rsp_now_empty  = out_empty_ff;
   assign rsp_now_full   = out_full_ff;

endmodule

`default_nettype wire

@@ hw/rtl/cdq_checker.sv @@
// Port-level checker for the circular deque unit, bound to the top level.
// Depends on cdq_pkg and circular_deque_unit_defines.svh.
`default_nettype none
`include "circular_deque_unit_defines.svh"

module cdq_checker import cdq_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [31:0] rsp_read_value,
   input wire logic [1:0]         rsp_status,
   input wire logic               rsp_now_empty,
   input wire logic               rsp_now_full
);

   // A deque of two or more slots is never both empty and full
   `CDQ_ASSERT_IMP(a_empty_not_full, rsp_valid && rsp_now_empty, !rsp_now_full)

   // A refused insert leaves the deque full and reads zero
   `CDQ_ASSERT_IMP(a_refused_full, rsp_valid && (rsp_status == ST_FULL), rsp_now_full && (rsp_read_value == 32'sd0))

   // A refused delete leaves the deque empty and reads minus one
   `CDQ_ASSERT_IMP(a_refused_empty, rsp_valid && (rsp_status == ST_EMPTY), rsp_now_empty && (rsp_read_value == -32'sd1))

   // Hold a stalled response
   `CDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value) && $stable(rsp_status))

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (.*);

`default_nettype wire

@@ verif/circular_deque_unit_tb.sv @@
// Self-checking testbench for circular_deque_unit: directed, random and backpressure tests.
// Depends on cdq_pkg and the circular_deque_unit RTL; keeps its own shadow of the deque.

module circular_deque_unit_tb;
   import cdq_pkg::*;

   localparam int unsigned DEQUE_DEPTH = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RSP_HOLD_CYCLES = 40;

   typedef struct packed {
      logic [31:0] read_value;
      status_type  status;
      logic        now_empty;
      logic        now_full;
   } deque_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_command = 2'd0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_read_value;
   logic [1:0]         rsp_status;
   logic               rsp_now_empty;
   logic               rsp_now_full;

   // Shadow copy of the deque
   logic [31:0] shadow_slots [DEQUE_DEPTH];
   int unsigned shadow_front = 0;
   int unsigned shadow_rear = 0;
   bit          shadow_empty = 1'b1;

   deque_rsp_type awaited_rsp [$];
   int  mismatch_count = 0;
   int  send_gap_max = 15;
   int  recv_gap_max = 15;
   bit  hold_responses = 1'b0;
   int  quiet_cycles = 0;

   circular_deque_unit #(.DEPTH(DEQUE_DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_now_empty  (rsp_now_empty),
      .rsp_now_full   (rsp_now_full)
   );

   always #5 clock = ~clock;

   function automatic int unsigned slot_after(input int unsigned i);
      return (i + 1 >= DEQUE_DEPTH) ? 0 : i + 1;
   endfunction

   function automatic int unsigned slot_before(input int unsigned i);
      return (i == 0) ? DEQUE_DEPTH - 1 : i - 1;
   endfunction

   function automatic bit shadow_full();
      return !shadow_empty && slot_after(shadow_rear) == shadow_front;
   endfunction

   // Advance the shadow deque by one command and return the response it implies
   function automatic deque_rsp_type apply_command(input cmd_type cmd, input logic [31:0] val);
      deque_rsp_type r;
      int unsigned   slot;
      r.read_value = '0;
      r.status     = ST_DONE;
      if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
         if (shadow_full()) begin
            r.status = ST_FULL;
         end else begin
            // first word always lands in slot 0, whichever end was named
            if (shadow_empty) begin
               shadow_front = 0;
               shadow_rear  = 0;
               shadow_empty = 1'b0;
               slot = 0;
            end else if (cmd == CMD_PUSH_FRONT) begin
               shadow_front = slot_before(shadow_front);
               slot = shadow_front;
            end else begin
               shadow_rear = slot_after(shadow_rear);
               slot = shadow_rear;
            end
            shadow_slots[slot] = val;
         end
      end else begin
         if (shadow_empty) begin
            r.status     = ST_EMPTY;
            r.read_value = REFUSED_READ;
         end else begin
            slot = (cmd == CMD_POP_FRONT) ? shadow_front : shadow_rear;
            r.read_value = shadow_slots[slot];
            // last word out: indices return to 0
            if (shadow_front == shadow_rear) begin
               shadow_empty = 1'b1;
               shadow_front = 0;
               shadow_rear  = 0;
            end else if (cmd == CMD_POP_FRONT) begin
               shadow_front = slot_after(shadow_front);
            end else begin
               shadow_rear = slot_before(shadow_rear);
            end
         end
      end
      r.now_empty = shadow_empty;
      r.now_full  = shadow_full();
      return r;
   endfunction

   // Offer one request after a random gap and hold it until accepted
   task automatic send_item(input cmd_type cmd, input logic [31:0] val);
      int gap;
      gap = $urandom_range(send_gap_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= val;
      do @(posedge clock); while (!(req_valid && req_ready));
      awaited_rsp.push_back(apply_command(cmd, val));
   endtask

   // Drop valid and wait until every expected transaction has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] expv,
                                input logic [31:0] actv);
      if (expv !== actv) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
         mismatch_count++;
      end
   endtask

   // Extremes of the value, first insert from either end, full and empty refusals
   task automatic test_directed();
      send_item(CMD_POP_FRONT, $urandom());
      send_item(CMD_POP_REAR, $urandom());
      send_item(CMD_PUSH_FRONT, 32'h8000_0000);
      send_item(CMD_POP_REAR, $urandom());
      send_item(CMD_PUSH_REAR, 32'h7FFF_FFFF);
      send_item(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
      send_item(CMD_PUSH_FRONT, 32'h0000_0000);
      send_item(CMD_PUSH_REAR, 32'hAAAA_AAAA);
      send_item(CMD_PUSH_REAR, 32'h5555_5555);
      send_item(CMD_PUSH_FRONT, 32'h8000_0000);
      send_item(CMD_PUSH_REAR, 32'h7FFF_FFFF);
      send_item(CMD_PUSH_FRONT, 32'h1234_5678);
      send_item(CMD_PUSH_FRONT, 32'hDEAD_BEEF);
      send_item(CMD_PUSH_REAR, 32'hFFFF_FFFF);
      for (int i = 0; i < 8; i++) begin
         send_item((i % 2 == 0) ? CMD_POP_FRONT : CMD_POP_REAR, $urandom());
      end
      send_item(CMD_POP_FRONT, 32'hFFFF_FFFF);
      wait_drained();
   endtask

   // Random walk between empty and full, with some stretches free of idling
   task automatic test_random();
      int      push_bias;
      bit      is_push;
      cmd_type cmd;
      for (int chunk = 0; chunk < 20; chunk++) begin
         case ($urandom_range(2, 0))
            0: push_bias = 15;
            1: push_bias = 50;
            default: push_bias = 85;
         endcase
         send_gap_max = (chunk % 4 == 3) ? 0 : 15;
         recv_gap_max = (chunk % 4 == 3) ? 0 : 15;
         for (int i = 0; i < 20; i++) begin
            is_push = ($urandom_range(99, 0) < push_bias);
            cmd = cmd_type'({!is_push, 1'($urandom_range(1, 0))});
            send_item(cmd, $urandom());
         end
      end
      send_gap_max = 15;
      recv_gap_max = 15;
      wait_drained();
   endtask

   // Stall the response side long enough that the unit fills and drops req_ready
   task automatic test_backpressure();
      send_gap_max   = 0;
      hold_responses = 1'b1;
      for (int i = 0; i < 32; i++) begin
         send_item(cmd_type'(2'($urandom_range(3, 0))), $urandom());
      end
      wait_drained();
      for (int i = 0; i < 6; i++) begin
         send_item(cmd_type'(2'($urandom_range(3, 0))), $urandom());
      end
      send_gap_max = 15;
      wait_drained();
   endtask

   // Response side: random stalls, long hold on request, check each transaction
   initial begin
      int            stall;
      deque_rsp_type exp_rsp;
      while (reset) @(posedge clock);
      forever begin
         if (hold_responses) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_responses = 1'b0;
         end
         stall = $urandom_range(recv_gap_max, 0);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready) && !hold_responses) @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h %h %b %b",
                        $time, rsp_read_value, rsp_status, rsp_now_empty, rsp_now_full);
               mismatch_count++;
            end else begin
               exp_rsp = awaited_rsp.pop_front();
               compare_field("read_value", exp_rsp.read_value, rsp_read_value);
               compare_field("status", 32'(exp_rsp.status), 32'(rsp_status));
               compare_field("now_empty", 32'(exp_rsp.now_empty), 32'(rsp_now_empty));
               compare_field("now_full", 32'(exp_rsp.now_full), 32'(rsp_now_full));
            end
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d responses outstanding",
                  $time, awaited_rsp.size());
         $display("circular_deque_unit_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("circular_deque_unit_tb passed");
      end else begin
         $display("circular_deque_unit_tb failed");
      end
      $finish;
   end

endmodule

@@ circular_deque_unit.f @@
+incdir+hw/rtl
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ram.sv
hw/rtl/circular_deque_unit.sv
hw/rtl/cdq_checker.sv
verif/circular_deque_unit_tb.sv
